// ===== src/pva_pkg.sv =====
`timescale 1ns / 1ps
// pva_pkg: shared types and constants of the voice allocator
// no dependencies

package pva_pkg;

  localparam int unsigned NumVoices = 16;
  localparam int unsigned VoiceW    = 4;
  localparam int unsigned CountW    = 5;
  localparam int unsigned NoteW     = 7;
  localparam int unsigned VelW      = 7;
  localparam int unsigned ReqW      = 2;

  typedef enum logic [ReqW-1:0] {
    REQ_NOTE_ON    = 2'd0,
    REQ_NOTE_OFF   = 2'd1,
    REQ_VOICE_DONE = 2'd2
  } req_e;

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

  typedef struct packed {
    logic [VoiceW-1:0] voice;
    logic [NoteW-1:0]  note;
  } age_entry_t;

  typedef struct packed {
    cmd_e              command;
    logic [VoiceW-1:0] voice;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   velocity;
    logic              stolen;
    logic              last;
  } out_word_t;

endpackage

// ===== src/poly_voice_allocator_oldest_steal.sv =====
`timescale 1ns / 1ps
// poly_voice_allocator_oldest_steal: voice allocator with oldest note stealing
// depends on pva_pkg; busy voices and their notes live in one age-ordered ram
// note on: S_START or S_STEAL registers the start word once the output is free, then idle
// note off: S_OFF scans every busy entry, then S_FLUSH sends the last release when a voice matches, then idle
// voice finished: S_FIN scans every busy entry and closes the gap; ignored words go back to idle
// in_ready only in idle, so a new word waits for the last; reset: 16 voices free, voice 0 on top, none busy

module poly_voice_allocator_oldest_steal
  import pva_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [ReqW-1:0]   req_type_i,
  input  logic [NoteW-1:0]  note_i,
  input  logic [VelW-1:0]   velocity_i,
  input  logic [VoiceW-1:0] voice_index_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              command_o,
  output logic [VoiceW-1:0] target_voice_o,
  output logic [NoteW-1:0]  note_out_o,
  output logic [VelW-1:0]   velocity_out_o,
  output logic              stolen_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_STEAL,
    S_OFF,
    S_FLUSH,
    S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [CountW-1:0]   max_q;
  logic [CountW-1:0]   busy_q, busy_d;
  logic [CountW-1:0]   fc_q, fc_d;
  logic [VoiceW-1:0]   head_q, head_d;
  logic [VoiceW-1:0]   pos_q, pos_d;
  logic                found_q, found_d;
  logic                pend_valid_q, pend_valid_d;
  logic [VoiceW-1:0]   pend_voice_q, pend_voice_d;
  logic [NumVoices-1:0] voice_busy_q, voice_busy_d;
  logic [VoiceW-1:0]   free_stack_q [NumVoices];
  logic [VoiceW-1:0]   free_init [NumVoices];
  logic [NoteW-1:0]    note_q, note_d;
  logic [VelW-1:0]     vel_q, vel_d;
  logic [VoiceW-1:0]   vidx_q, vidx_d;
  logic                out_valid_q, out_valid_d;
  out_word_t           out_q, out_d;

  logic                push_en;
  logic [CountW-1:0]   cfg_max;
  logic                out_free;
  logic                is_end;
  logic                match;
  logic                steal;
  logic [VoiceW-1:0]   pop_voice;

  // age ram
  age_entry_t          age_mem [NumVoices];
  age_entry_t          rdata_q;
  logic                mem_we;
  logic [VoiceW-1:0]   mem_waddr;
  age_entry_t          mem_wdata;
  logic [VoiceW-1:0]   rd_addr;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      age_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= age_mem[rd_addr];
  end

  always_comb begin
    if (cfg_wdata_i == '0) begin
      cfg_max = CountW'(1);
    end else if (cfg_wdata_i > CountW'(NumVoices)) begin
      cfg_max = CountW'(NumVoices);
    end else begin
      cfg_max = cfg_wdata_i;
    end
    for (int i = 0; i < NumVoices; i++) begin
      free_init[i] = (CountW'(i) < cfg_max) ?
                     VoiceW'(cfg_max - CountW'(i) - CountW'(1)) : '0;
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign is_end    = ((CountW'(pos_q) + CountW'(1)) == busy_q);
  assign match     = (rdata_q.note == note_q);
  assign steal     = (busy_q >= max_q) || (fc_q == '0 && busy_q != '0);
  assign pop_voice = free_stack_q[VoiceW'(fc_q - CountW'(1))];
  assign rd_addr   = head_d + pos_d;

  always_comb begin
    state_d      = state_q;
    busy_d       = busy_q;
    fc_d         = fc_q;
    head_d       = head_q;
    pos_d        = pos_q;
    found_d      = found_q;
    pend_valid_d = pend_valid_q;
    pend_voice_d = pend_voice_q;
    voice_busy_d = voice_busy_q;
    note_d       = note_q;
    vel_d        = vel_q;
    vidx_d       = vidx_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_d        = out_q;
    push_en      = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          note_d       = note_i;
          vel_d        = velocity_i;
          vidx_d       = voice_index_i;
          pos_d        = '0;
          found_d      = 1'b0;
          pend_valid_d = 1'b0;
          unique case (req_type_i)
            REQ_NOTE_ON: begin
              if (steal) begin
                state_d = S_STEAL;
              end else if (fc_q != '0) begin
                state_d = S_START;
              end
            end
            REQ_NOTE_OFF: begin
              if (busy_q != '0) begin
                state_d = S_OFF;
              end
            end
            REQ_VOICE_DONE: begin
              if ((CountW'(voice_index_i) < max_q) && voice_busy_q[voice_index_i]) begin
                state_d = S_FIN;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_START: begin
        if (out_free) begin
          fc_d                    = fc_q - CountW'(1);
          busy_d                  = busy_q + CountW'(1);
          voice_busy_d[pop_voice] = 1'b1;
          mem_we                  = 1'b1;
          mem_waddr               = head_q + VoiceW'(busy_q);
          mem_wdata               = '{voice: pop_voice, note: note_q};
          out_valid_d             = 1'b1;
          out_d                   = '{command: CMD_START, voice: pop_voice, note: note_q,
                                      velocity: vel_q, stolen: 1'b0, last: 1'b1};
          state_d                 = S_IDLE;
        end
      end

      S_STEAL: begin
        if (out_free) begin
          // oldest entry moves to the newest place
          head_d      = head_q + VoiceW'(1);
          mem_we      = 1'b1;
          mem_waddr   = head_q + VoiceW'(busy_q);
          mem_wdata   = '{voice: rdata_q.voice, note: note_q};
          out_valid_d = 1'b1;
          out_d       = '{command: CMD_START, voice: rdata_q.voice, note: note_q,
                          velocity: vel_q, stolen: 1'b1, last: 1'b1};
          state_d     = S_IDLE;
        end
      end

      S_OFF: begin
        if (!(match && pend_valid_q && !out_free)) begin
          if (match) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = '{command: CMD_RELEASE, voice: pend_voice_q, note: note_q,
                              velocity: vel_q, stolen: 1'b0, last: 1'b0};
            end
            pend_valid_d = 1'b1;
            pend_voice_d = rdata_q.voice;
          end
          if (is_end) begin
            state_d = (match || pend_valid_q) ? S_FLUSH : S_IDLE;
          end else begin
            pos_d = pos_q + VoiceW'(1);
          end
        end
      end

      S_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = '{command: CMD_RELEASE, voice: pend_voice_q, note: note_q,
                           velocity: vel_q, stolen: 1'b0, last: 1'b1};
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      S_FIN: begin
        if (found_q) begin
          // close the gap left by the finished voice
          mem_we    = 1'b1;
          mem_waddr = head_q + pos_q - VoiceW'(1);
          mem_wdata = rdata_q;
        end else if (rdata_q.voice == vidx_q) begin
          found_d = 1'b1;
        end
        if (is_end) begin
          if (found_q || rdata_q.voice == vidx_q) begin
            busy_d = busy_q - CountW'(1);
          end
          voice_busy_d[vidx_q] = 1'b0;
          if (fc_q < CountW'(NumVoices)) begin
            push_en = 1'b1;
            fc_d    = fc_q + CountW'(1);
          end
          state_d = S_IDLE;
        end else begin
          pos_d = pos_q + VoiceW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      max_q        <= CountW'(NumVoices);
      busy_q       <= '0;
      fc_q         <= CountW'(NumVoices);
      head_q       <= '0;
      pos_q        <= '0;
      found_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_voice_q <= '0;
      voice_busy_q <= '0;
      note_q       <= '0;
      vel_q        <= '0;
      vidx_q       <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
      for (int i = 0; i < NumVoices; i++) begin
        free_stack_q[i] <= VoiceW'(NumVoices - 1 - i);
      end
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      found_q      <= found_d;
      pend_valid_q <= pend_valid_d;
      pend_voice_q <= pend_voice_d;
      note_q       <= note_d;
      vel_q        <= vel_d;
      vidx_q       <= vidx_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      if (cfg_we_i) begin
        // free all voices
        max_q        <= cfg_max;
        busy_q       <= '0;
        fc_q         <= cfg_max;
        head_q       <= '0;
        voice_busy_q <= '0;
        for (int i = 0; i < NumVoices; i++) begin
          free_stack_q[i] <= free_init[i];
        end
      end else begin
        busy_q       <= busy_d;
        fc_q         <= fc_d;
        head_q       <= head_d;
        voice_busy_q <= voice_busy_d;
        if (push_en) begin
          free_stack_q[fc_q[VoiceW-1:0]] <= vidx_q;
        end
      end
    end
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign command_o      = out_q.command;
  assign target_voice_o = out_q.voice;
  assign note_out_o     = out_q.note;
  assign velocity_out_o = out_q.velocity;
  assign stolen_o       = out_q.stolen;
  assign last_o         = out_q.last;

  a_count_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (6'(busy_q) + 6'(fc_q)) <= 6'(max_q))
    else $error("busy and free voices exceed max_voices");

  a_busy_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(voice_busy_q) == int'(busy_q))
    else $error("busy flags disagree with busy count");

  a_max_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    max_q != '0 && max_q <= CountW'(NumVoices))
    else $error("max_voices out of range");

  a_pend_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FLUSH) |-> pend_valid_q)
    else $error("flush without a pending release");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// testbench: checks poly_voice_allocator_oldest_steal against its own voice allocation predictor
// depends on pva_pkg and the allocator rtl; directed table first, then random phases

module testbench;
  import pva_pkg::*;

  localparam logic [ReqW-1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned MaxReleases = 16;
  localparam int unsigned SettleCycles = 40;
  localparam int unsigned PhaseItems = 64;

  typedef enum {CHECK_MODEL, CHECK_NONE, CHECK_ONE, SET_LIMIT} row_kind_e;

  typedef struct {
    row_kind_e         kind;
    logic [ReqW-1:0]   req;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
    logic [VoiceW-1:0] voice;
    logic [CountW-1:0] limit;
    out_word_t         want;
  } plan_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [ReqW-1:0]   req_type_i;
  logic [NoteW-1:0]  note_i;
  logic [VelW-1:0]   velocity_i;
  logic [VoiceW-1:0] voice_index_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic              command_o;
  logic [VoiceW-1:0] target_voice_o;
  logic [NoteW-1:0]  note_out_o;
  logic [VelW-1:0]   velocity_out_o;
  logic              stolen_o;
  logic              last_o;

  // predicted allocator state
  logic [VoiceW-1:0] age_q[NumVoices];
  logic [VoiceW-1:0] free_q[NumVoices];
  logic [NoteW-1:0]  note_of[NumVoices];
  bit                busy_of[NumVoices];
  int unsigned       n_busy;
  int unsigned       n_free;
  int unsigned       voices_in_use;

  out_word_t step_words[$];
  out_word_t due_words[$];
  plan_row_t plan[$];

  int fail_count = 0;
  int gap_pct = 20;
  int stall_pct = 20;
  int chord_left = 0;
  logic [NoteW-1:0] chord_note = '0;

  int                gap_by_phase[7]   = '{20, 10, 0, 30, 15, 25, 0};
  int                stall_by_phase[7] = '{15, 30, 10, 0, 20, 25, 0};
  logic [CountW-1:0] limit_by_phase[7] = '{5'd16, 5'd1, 5'd31, 5'd0, 5'd3, 5'd17, 5'd16};

  poly_voice_allocator_oldest_steal DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .req_type_i     (req_type_i),
    .note_i         (note_i),
    .velocity_i     (velocity_i),
    .voice_index_i  (voice_index_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .command_o      (command_o),
    .target_voice_o (target_voice_o),
    .note_out_o     (note_out_o),
    .velocity_out_o (velocity_out_o),
    .stolen_o       (stolen_o),
    .last_o         (last_o)
  );

  function automatic out_word_t make_word(cmd_e cmd, int voice, int note, int vel,
                                          bit stolen, bit last);
    out_word_t w;
    w.command  = cmd;
    w.voice    = voice[VoiceW-1:0];
    w.note     = note[NoteW-1:0];
    w.velocity = vel[VelW-1:0];
    w.stolen   = stolen;
    w.last     = last;
    return w;
  endfunction

  function automatic plan_row_t row(row_kind_e kind, logic [ReqW-1:0] req, int note, int vel,
                                    int voice, out_word_t want);
    plan_row_t r;
    r.kind  = kind;
    r.req   = req;
    r.note  = note[NoteW-1:0];
    r.vel   = vel[VelW-1:0];
    r.voice = voice[VoiceW-1:0];
    r.limit = '0;
    r.want  = want;
    return r;
  endfunction

  function automatic plan_row_t limit_row(logic [CountW-1:0] value);
    plan_row_t r;
    r = row(SET_LIMIT, REQ_NOTE_ON, 0, 0, 0, '0);
    r.limit = value;
    return r;
  endfunction

  function automatic void add_row(plan_row_t r);
    plan.insert(plan.size(), r);
  endfunction

  function automatic void set_voice_limit(logic [CountW-1:0] value);
    int i;
    if (value < 1) voices_in_use = 1;
    else if (value > NumVoices) voices_in_use = NumVoices;
    else voices_in_use = value;
    n_busy = 0;
    n_free = voices_in_use;
    for (i = 0; i < NumVoices; i++) begin
      age_q[i]   = '0;
      free_q[i]  = '0;
      note_of[i] = '0;
      busy_of[i] = 1'b0;
    end
    for (i = 0; i < voices_in_use; i++) free_q[i] = VoiceW'(voices_in_use - 1 - i);
  endfunction

  function automatic void drop_from_age(int unsigned pos);
    int unsigned i;
    for (i = pos; i + 1 < n_busy; i++) age_q[i] = age_q[i + 1];
    n_busy--;
  endfunction

  function automatic void allocate_voices(logic [ReqW-1:0] req, logic [NoteW-1:0] note,
                                          logic [VelW-1:0] vel, logic [VoiceW-1:0] voice);
    logic [VoiceW-1:0] v;
    int unsigned i;
    step_words.delete();
    case (req)
      REQ_NOTE_ON: begin
        if (n_busy >= voices_in_use || (n_free == 0 && n_busy > 0)) begin
          // steal the oldest voice, it becomes the newest
          v = age_q[0];
          drop_from_age(0);
          age_q[n_busy] = v;
          n_busy++;
          note_of[v] = note;
          step_words.insert(step_words.size(),
                            make_word(CMD_START, v, note, vel, 1'b1, 1'b1));
        end else if (n_free > 0) begin
          n_free--;
          v = free_q[n_free];
          age_q[n_busy] = v;
          n_busy++;
          note_of[v] = note;
          busy_of[v] = 1'b1;
          step_words.insert(step_words.size(),
                            make_word(CMD_START, v, note, vel, 1'b0, 1'b1));
        end
      end
      REQ_NOTE_OFF: begin
        for (i = 0; i < n_busy && step_words.size() < MaxReleases; i++) begin
          if (note_of[age_q[i]] == note)
            step_words.insert(step_words.size(),
                              make_word(CMD_RELEASE, age_q[i], note, vel, 1'b0, 1'b0));
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
      end
      REQ_VOICE_DONE: begin
        if (voice < voices_in_use && busy_of[voice]) begin
          for (i = 0; i < n_busy; i++) begin
            if (age_q[i] == voice) begin
              drop_from_age(i);
              break;
            end
          end
          busy_of[voice] = 1'b0;
          if (n_free < NumVoices) begin
            free_q[n_free] = voice;
            n_free++;
          end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    fail_count++;
    if (fail_count <= 100) $display("mismatch %s: got %0d, want %0d", what, got, want);
  endtask

  task automatic wait_all_words();
    do @(negedge clk_i); while (due_words.size() != 0);
  endtask

  task automatic send_request(input logic [ReqW-1:0] req, input logic [NoteW-1:0] note,
                              input logic [VelW-1:0] vel, input logic [VoiceW-1:0] voice,
                              input row_kind_e kind, input out_word_t want);
    int gap;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 14) : 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    note_i        <= note;
    velocity_i    <= vel;
    voice_index_i <= voice;
    do @(posedge clk_i); while (!in_ready_o);
    allocate_voices(req, note, vel, voice);
    if (kind == CHECK_MODEL) begin
      foreach (step_words[i]) due_words.insert(due_words.size(), step_words[i]);
    end else if (kind == CHECK_ONE) begin
      due_words.insert(due_words.size(), want);
    end
    @(negedge clk_i);
  endtask

  task automatic write_voice_limit(input logic [CountW-1:0] value);
    in_valid_i <= 1'b0;
    wait_all_words();
    repeat (SettleCycles) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    set_voice_limit(value);
  endtask

  task automatic send_random_request();
    logic [ReqW-1:0]   req;
    logic [NoteW-1:0]  note;
    logic [VelW-1:0]   vel;
    logic [VoiceW-1:0] voice;
    int pick;
    pick  = $urandom_range(0, 99);
    vel   = VelW'($urandom_range(0, 127));
    voice = VoiceW'($urandom_range(0, 15));
    case ($urandom_range(0, 5))
      0, 1:    note = NoteW'($urandom_range(0, 127));
      2:       note = NoteW'(0);
      3:       note = NoteW'(127);
      4:       note = NoteW'(64);
      default: note = NoteW'(63);
    endcase
    // chord: fill every voice with one note, then release them all
    if (chord_left == 0 && $urandom_range(0, 59) == 0) begin
      chord_left = voices_in_use + 1;
      chord_note = note;
    end
    if (chord_left > 1) begin
      req = REQ_NOTE_ON;
      note = chord_note;
      chord_left--;
    end else if (chord_left == 1) begin
      req = REQ_NOTE_OFF;
      note = chord_note;
      chord_left = 0;
    end else if (pick < 40) begin
      req = REQ_NOTE_ON;
    end else if (pick < 65) begin
      req = REQ_NOTE_OFF;
      if (n_busy > 0 && $urandom_range(0, 9) < 7)
        note = note_of[age_q[$urandom_range(0, n_busy - 1)]];
    end else if (pick < 95) begin
      req = REQ_VOICE_DONE;
      if (n_busy > 0 && pick < 90) voice = age_q[$urandom_range(0, n_busy - 1)];
    end else begin
      req = REQ_UNUSED;
    end
    send_request(req, note, vel, voice, CHECK_MODEL, '0);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    int stall;
    stall = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else begin
        out_ready_i <= 1'b1;
        if ($urandom_range(0, 99) < stall_pct) stall = $urandom_range(1, 14);
      end
    end
  end

  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (due_words.size() == 0) begin
        report_mismatch("unexpected word, voice", target_voice_o, -1);
      end else begin
        want = due_words[0];
        due_words.delete(0);
        if (command_o !== want.command) report_mismatch("command", command_o, want.command);
        if (target_voice_o !== want.voice) report_mismatch("voice", target_voice_o, want.voice);
        if (note_out_o !== want.note) report_mismatch("note", note_out_o, want.note);
        if (velocity_out_o !== want.velocity)
          report_mismatch("velocity", velocity_out_o, want.velocity);
        if (stolen_o !== want.stolen) report_mismatch("stolen", stolen_o, want.stolen);
        if (last_o !== want.last) report_mismatch("last", last_o, want.last);
      end
    end
  end

  initial begin
    #10_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int ph;
    int n;
    logic [CountW-1:0] limit;
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    in_valid_i    = 1'b0;
    req_type_i    = '0;
    note_i        = '0;
    velocity_i    = '0;
    voice_index_i = '0;
    set_voice_limit(NumVoices);

    add_row(row(CHECK_ONE, REQ_NOTE_ON, 0, 0, 0,
                make_word(CMD_START, 0, 0, 0, 1'b0, 1'b1)));
    add_row(row(CHECK_ONE, REQ_NOTE_ON, 127, 127, 15,
                make_word(CMD_START, 1, 127, 127, 1'b0, 1'b1)));
    add_row(row(CHECK_ONE, REQ_NOTE_OFF, 0, 5, 0,
                make_word(CMD_RELEASE, 0, 0, 5, 1'b0, 1'b1)));
    add_row(row(CHECK_NONE, REQ_NOTE_OFF, 55, 1, 0, '0));
    add_row(row(CHECK_NONE, REQ_VOICE_DONE, 0, 0, 0, '0));
    add_row(row(CHECK_NONE, REQ_VOICE_DONE, 0, 0, 0, '0));
    add_row(row(CHECK_NONE, REQ_VOICE_DONE, 127, 127, 15, '0));
    add_row(row(CHECK_NONE, REQ_UNUSED, 127, 127, 15, '0));
    add_row(row(CHECK_MODEL, REQ_NOTE_ON, 60, 64, 0, '0));
    add_row(row(CHECK_MODEL, REQ_NOTE_OFF, 127, 127, 0, '0));
    add_row(limit_row(5'd2));
    add_row(row(CHECK_ONE, REQ_NOTE_ON, 64, 10, 0,
                make_word(CMD_START, 0, 64, 10, 1'b0, 1'b1)));
    add_row(row(CHECK_MODEL, REQ_NOTE_ON, 64, 20, 0, '0));
    add_row(row(CHECK_ONE, REQ_NOTE_ON, 64, 30, 0,
                make_word(CMD_START, 0, 64, 30, 1'b1, 1'b1)));
    add_row(row(CHECK_MODEL, REQ_NOTE_OFF, 64, 40, 0, '0));
    add_row(row(CHECK_NONE, REQ_VOICE_DONE, 0, 0, 5, '0));
    add_row(row(CHECK_MODEL, REQ_VOICE_DONE, 0, 0, 1, '0));
    add_row(row(CHECK_MODEL, REQ_NOTE_ON, 9, 90, 0, '0));
    add_row(limit_row(5'd0));
    add_row(row(CHECK_ONE, REQ_NOTE_ON, 100, 3, 0,
                make_word(CMD_START, 0, 100, 3, 1'b0, 1'b1)));
    add_row(row(CHECK_ONE, REQ_NOTE_ON, 101, 7, 0,
                make_word(CMD_START, 0, 101, 7, 1'b1, 1'b1)));
    add_row(row(CHECK_NONE, REQ_VOICE_DONE, 0, 0, 1, '0));
    add_row(limit_row(5'd31));
    add_row(row(CHECK_MODEL, REQ_NOTE_ON, 0, 127, 0, '0));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == SET_LIMIT) write_voice_limit(plan[k].limit);
      else send_request(plan[k].req, plan[k].note, plan[k].vel, plan[k].voice,
                        plan[k].kind, plan[k].want);
    end

    for (ph = 0; ph < 7; ph++) begin
      gap_pct   = gap_by_phase[ph];
      stall_pct = stall_by_phase[ph];
      limit     = (ph == 4) ? CountW'($urandom_range(2, 15)) : limit_by_phase[ph];
      chord_left = 0;
      write_voice_limit(limit);
      for (n = 0; n < PhaseItems; n++) begin
        // hold off until every word is out
        if (ph == 1 && n == PhaseItems / 2) begin
          in_valid_i <= 1'b0;
          wait_all_words();
        end
        send_random_request();
      end
    end

    in_valid_i <= 1'b0;
    wait_all_words();
    repeat (SettleCycles) @(negedge clk_i);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/pva_pkg.sv
src/poly_voice_allocator_oldest_steal.sv
dv/testbench.sv
